// File: hdl/slot_free_list_allocator_defines.svh
`ifndef SLOT_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define SLOT_FREE_LIST_ALLOCATOR_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define SFLA_ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define SFLA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SFLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/sfla_pkg.sv
package sfla_pkg;

    localparam int SLOT_W   = 10;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int LIVE_W   = 11;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [MODE_W-1:0] {
        MODE_RESERVE     = 2'd0,
        MODE_RELEASE     = 2'd1,
        MODE_RELEASE_ALL = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_REJECT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_FIN
    } t_state;

endpackage

// File: hdl/slot_free_list_allocator.sv
// Channel   Direction  tdata (low bit up)                 tuser
// s_axis    in         slot[9:0], zero pad to 16 bits     mode[1:0]
// m_axis    out        granted_slot[9:0], live_count[20:10],
//                      zero pad to 24 bits                status[1:0]
// A reserve or a single release is accepted in S_IDLE and executed in S_EXEC, in which the registered
// read of the free-flag and link memories is evaluated and written back once the output is free.
// A release of all slots walks every slot below the used capacity, checking one slot per cycle
// and freeing it if reserved, bounded by the single write port of the free-flag memory.
// Reset is synchronous and needs no clearing pass; a free flag above the used capacity is never
// used before growth writes it.
// A request is taken while a result waits in the output register; the next result then stalls.
`include "slot_free_list_allocator_defines.svh"

module slot_free_list_allocator #(
    parameter int SLOT_COUNT = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // slot[9:0], zero pad
    input  logic [sfla_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // mode[1:0]
    input  logic [sfla_pkg::MODE_W-1:0]      i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // granted_slot[9:0], live_count[20:10], zero pad
    output logic [sfla_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // status[1:0]
    output logic [sfla_pkg::STATUS_W-1:0]    o_m_axis_tuser
);
    import sfla_pkg::*;

    localparam int IW   = $clog2(SLOT_COUNT);
    localparam int CW   = $clog2(SLOT_COUNT + 1);
    localparam int SXW  = (IW > SLOT_W) ? IW : SLOT_W;
    localparam int CMPW = (CW > SLOT_W) ? CW : SLOT_W;
    localparam int LXW  = (CW > LIVE_W) ? CW : LIVE_W;
    localparam int PADW = OUT_DATA_W - LIVE_W - SLOT_W;

    logic [IW-1:0] mem_link [SLOT_COUNT];
    logic          mem_free [SLOT_COUNT];

    t_state               r_state, n_state;
    t_mode                r_mode;
    logic [SLOT_W-1:0]    r_slot;
    logic [IW-1:0]        r_head, n_head;
    logic [IW-1:0]        r_tail, n_tail;
    logic                 r_nonempty, n_nonempty;
    logic [CW-1:0]        r_cap, n_cap;
    logic [CW-1:0]        r_live, n_live;
    logic [CW-1:0]        r_walk_idx, n_walk_idx;
    logic                 r_chk_vld, n_chk_vld;
    logic [IW-1:0]        r_chk_idx, n_chk_idx;
    logic                 r_rd_free;
    logic [IW-1:0]        r_rd_link;
    logic                 r_out_valid, n_out_valid;
    logic [SLOT_W-1:0]    r_out_slot, n_out_slot;
    t_status              r_out_status, n_out_status;
    logic [LIVE_W-1:0]    r_out_live, n_out_live;

    logic                 in_accept;
    logic                 out_free;
    logic [SXW-1:0]       in_slot_x, req_slot_x;
    logic [IW-1:0]        req_idx;
    logic [IW-1:0]        free_raddr;
    logic                 free_we, free_wdata;
    logic [IW-1:0]        free_waddr;
    logic                 link_we;
    logic [IW-1:0]        link_waddr, link_wdata;
    logic                 rel_do;
    logic [IW-1:0]        rel_idx;
    logic                 res_do;
    logic [IW-1:0]        grant_idx;
    logic [SXW-1:0]       grant_x;
    logic [LXW-1:0]       live_x;

    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign in_slot_x       = SXW'(i_s_axis_tdata[SLOT_W-1:0]);
    assign req_slot_x      = SXW'(r_slot);
    assign req_idx         = req_slot_x[IW-1:0];
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {PADW'(0), r_out_live, r_out_slot};
    assign o_m_axis_tuser  = r_out_status;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    if (r_mode == MODE_RELEASE_ALL && r_cap != '0) begin
                        n_state = S_WALK;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_WALK: begin
                if (r_walk_idx == r_cap && !r_chk_vld) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_nonempty   = r_nonempty;
        n_cap        = r_cap;
        n_live       = r_live;
        n_walk_idx   = r_walk_idx;
        n_chk_vld    = 1'b0;
        n_chk_idx    = r_chk_idx;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_slot   = r_out_slot;
        n_out_status = r_out_status;
        n_out_live   = r_out_live;
        free_raddr   = '0;
        free_we      = 1'b0;
        free_waddr   = '0;
        free_wdata   = 1'b0;
        link_we      = 1'b0;
        link_waddr   = r_tail;
        link_wdata   = '0;
        rel_do       = 1'b0;
        rel_idx      = '0;
        res_do       = 1'b0;
        grant_idx    = '0;
        grant_x      = '0;
        live_x       = '0;

        unique case (r_state)
            S_IDLE:  free_raddr = in_slot_x[IW-1:0];
            S_EXEC:  free_raddr = req_idx;
            S_WALK:  free_raddr = r_walk_idx[IW-1:0];
            default: free_raddr = '0;
        endcase

        if (r_state == S_EXEC && out_free) begin
            n_out_valid  = 1'b1;
            n_out_status = ST_DONE;
            unique case (r_mode)
                MODE_RESERVE: begin
                    priority if (r_nonempty) begin
                        res_do    = 1'b1;
                        grant_idx = r_head;
                        if (r_head == r_tail) begin
                            n_nonempty = 1'b0;
                        end else begin
                            n_head = r_rd_link;
                        end
                    end else if (r_cap < CW'(SLOT_COUNT)) begin
                        res_do    = 1'b1;
                        grant_idx = r_cap[IW-1:0];
                        n_cap     = r_cap + CW'(1);
                    end else begin
                        n_out_status = ST_FULL;
                    end
                end
                MODE_RELEASE: begin
                    if (CMPW'(r_slot) < CMPW'(r_cap) && r_live != '0 && !r_rd_free) begin
                        rel_do  = 1'b1;
                        rel_idx = req_idx;
                    end else begin
                        n_out_status = ST_REJECT;
                    end
                end
                MODE_RELEASE_ALL: begin
                    n_walk_idx = '0;
                    if (r_cap != '0) begin
                        n_out_valid = r_out_valid && !i_m_axis_tready;
                    end
                end
                default: n_out_status = ST_REJECT;
            endcase
        end

        if (r_state == S_WALK) begin
            if (r_walk_idx != r_cap) begin
                n_chk_vld  = 1'b1;
                n_chk_idx  = r_walk_idx[IW-1:0];
                n_walk_idx = r_walk_idx + CW'(1);
            end
            if (r_chk_vld && r_live != '0 && !r_rd_free) begin
                rel_do  = 1'b1;
                rel_idx = r_chk_idx;
            end
        end

        if (r_state == S_FIN && out_free) begin
            n_out_valid  = 1'b1;
            n_out_status = ST_DONE;
        end

        if (res_do) begin
            free_we    = 1'b1;
            free_waddr = grant_idx;
            free_wdata = 1'b0;
            n_live     = r_live + CW'(1);
        end

        if (rel_do) begin
            free_we    = 1'b1;
            free_waddr = rel_idx;
            free_wdata = 1'b1;
            if (r_nonempty) begin
                link_we    = 1'b1;
                link_wdata = rel_idx;
            end else begin
                n_head = rel_idx;
            end
            n_tail     = rel_idx;
            n_nonempty = 1'b1;
            n_live     = r_live - CW'(1);
        end

        grant_x    = SXW'(grant_idx);
        live_x     = LXW'(n_live);
        if ((r_state == S_EXEC || r_state == S_FIN) && out_free) begin
            n_out_slot = grant_x[SLOT_W-1:0];
            n_out_live = live_x[LIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (free_we) begin
            mem_free[free_waddr] <= free_wdata;
        end
        r_rd_free <= mem_free[free_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            mem_link[link_waddr] <= link_wdata;
        end
        r_rd_link <= mem_link[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_nonempty  <= 1'b0;
            r_cap       <= '0;
            r_live      <= '0;
            r_walk_idx  <= '0;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_nonempty  <= n_nonempty;
            r_cap       <= n_cap;
            r_live      <= n_live;
            r_walk_idx  <= n_walk_idx;
            r_chk_vld   <= n_chk_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode <= t_mode'(i_s_axis_tuser);
            r_slot <= i_s_axis_tdata[SLOT_W-1:0];
        end
        r_chk_idx    <= n_chk_idx;
        r_out_slot   <= n_out_slot;
        r_out_status <= n_out_status;
        r_out_live   <= n_out_live;
    end

    `SFLA_ASSERT_HOLDS(a_live_within_cap, i_clk, i_rst_n, r_live <= r_cap, "live count above capacity")
    `SFLA_ASSERT_HOLDS(a_walk_within_cap, i_clk, i_rst_n, r_walk_idx <= r_cap, "walk beyond capacity")
    `SFLA_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, in_accept, r_state == S_EXEC, "request not executed")
    `SFLA_ASSERT_NEXT(a_cap_monotonic, i_clk, i_rst_n, 1'b1, r_cap >= $past(r_cap), "capacity shrank")
    `SFLA_ASSERT_IMPLIES(a_full_consistent, i_clk, i_rst_n, r_out_valid && r_out_status == ST_FULL, r_cap == CW'(SLOT_COUNT) && !r_nonempty && r_out_slot == '0, "full reported while slots remain")

endmodule
